FILE: src/bskv_pkg.sv
// bskv_pkg: shared types and codes of the key/value byte store engine
// no dependencies; imported by the front, back and top level modules
package bskv_pkg;

  // function codes of an input item
  localparam logic [2:0] FN_LOOKUP = 3'd0;
  localparam logic [2:0] FN_ERASE  = 3'd1;
  localparam logic [2:0] FN_HOLE   = 3'd2;
  localparam logic [2:0] FN_WRITE  = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;

  // configuration register indexes
  localparam int         CFG_IDX_W    = 1;
  localparam logic [0:0] CFG_DB_START = 1'b0;
  localparam logic [0:0] CFG_DB_END   = 1'b1;

  localparam logic [7:0] ERASED = 8'hFF;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_HOLE,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        erase;
    logic        last;
    logic [7:0]  data;
    logic [9:0]  address;
    logic [10:0] hole_size;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_REQ,
    S_RD_USE,
    S_LK_TOP,
    S_SF_REQ,
    S_SF_USE,
    S_KM_TOP,
    S_KM_USE,
    S_PS_REQ,
    S_PS_USE,
    S_BL_REQ,
    S_BL_USE,
    S_HL_TOP
  } state_t;

  typedef enum logic [1:0] {
    SF_LOOKUP,
    SF_HOLE_START,
    SF_HOLE_END
  } sf_ctx_t;

  typedef enum logic [1:0] {
    PS_VALUE,
    PS_SKIP_KEY,
    PS_SKIP_VALUE
  } ps_ctx_t;

endpackage

FILE: src/bskv_in_if.sv
// bskv_in_if: input channel of the engine, valid/ready with item payload
// no dependencies
interface bskv_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  data_byte;
  logic        last;
  logic [9:0]  address;
  logic [10:0] hole_size;

  modport source (output valid, func, data_byte, last, address, hole_size, input ready);
  modport sink (input valid, func, data_byte, last, address, hole_size, output ready);
endinterface

FILE: src/bskv_out_if.sv
// bskv_out_if: result channel of the engine, valid/ready with result payload
// no dependencies
interface bskv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  key_address;
  logic [10:0] value_address;
  logic [7:0]  read_data;

  modport source (output valid, status, key_address, value_address, read_data, input ready);
  modport sink (input valid, status, key_address, value_address, read_data, output ready);
endinterface

FILE: src/bskv_front.sv
// bskv_front: accepts items, classifies them into commands, two-entry queue
// depends on bskv_pkg and bskv_in_if
module bskv_front (
  input  logic                 clk,
  input  logic                 rst_n,
  bskv_in_if.sink              in_ch,
  input  bskv_pkg::back_stat_t bstat,
  output bskv_pkg::cmd_req_t   req
);
  import bskv_pkg::*;

  cmd_t       q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_in;
  logic       fn_ok;
  logic       accept, push;

  always_comb begin
    cmd_in.kind      = CMD_KEY;
    cmd_in.erase     = (in_ch.func == FN_ERASE);
    cmd_in.last      = in_ch.last;
    cmd_in.data      = in_ch.data_byte;
    cmd_in.address   = in_ch.address;
    cmd_in.hole_size = in_ch.hole_size;
    fn_ok            = 1'b1;
    unique case (in_ch.func) inside
      FN_LOOKUP, FN_ERASE: cmd_in.kind = CMD_KEY;
      FN_HOLE:             cmd_in.kind = CMD_HOLE;
      FN_WRITE:            cmd_in.kind = CMD_WRITE;
      FN_READ:             cmd_in.kind = CMD_READ;
      default:             fn_ok = 1'b0;  // unused codes are dropped
    endcase
  end

  assign in_ch.ready = !bstat.clearing && (cnt_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && fn_ok;

  assign req.valid = (cnt_r != 2'd0);
  assign req.cmd   = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (bstat.pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, bstat.pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= cmd_in;
  end

endmodule

FILE: src/bskv_back.sv
// bskv_back: byte store memory and the sequencer that runs each command
// depends on bskv_pkg and bskv_out_if
module bskv_back #(
  parameter int STORE_BYTES = 1024,
  parameter int KEY_MAX     = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bskv_pkg::cmd_req_t   req,
  output bskv_pkg::back_stat_t bstat,
  input  logic [9:0]           db_start,
  input  logic [10:0]          db_end,
  bskv_out_if.source           out_ch
);
  import bskv_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int PW  = (AW + 1 > 12) ? AW + 1 : 12;
  localparam int KLW = $clog2(KEY_MAX + 1);
  localparam int KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] kbuf_r [KEY_MAX];

  state_t          st_r, st_nxt;
  logic [PW-1:0]   p_r, p_nxt, at_r, at_nxt, vaddr_r, vaddr_nxt;
  logic [10:0]     size_r, size_nxt;
  logic [KLW-1:0]  klen_r, klen_nxt, i_r, i_nxt;
  logic            erase_r, erase_nxt, want_r, want_nxt, second_r, second_nxt;
  sf_ctx_t         sf_ctx_r, sf_ctx_nxt;
  ps_ctx_t         ps_ctx_r, ps_ctx_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [7:0]      rdata_r;
  logic            inr_r;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [9:0]      out_kaddr_r, out_kaddr_nxt;
  logic [10:0]     out_vaddr_r, out_vaddr_nxt;
  logic [7:0]      out_rdata_r, out_rdata_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_idx;
  logic [7:0]      byte_v;
  logic            pop, kbuf_we, emit, key_done;
  logic [1:0]      e_status;
  logic [PW-1:0]   e_kaddr, e_vaddr;
  logic [7:0]      e_rdata;
  logic            he_go, ps_go, bl_go, km_more;
  logic [PW-1:0]   he_end, ps_ret, bl_ret;
  logic [PW-1:0]   db_start_x, db_end_x, size_x, wr_addr_x;

  assign db_start_x = PW'(db_start);
  assign db_end_x   = PW'(db_end);
  assign size_x     = PW'(size_r);
  assign wr_addr_x  = PW'(req.cmd.address);
  assign byte_v     = inr_r ? rdata_r : ERASED;
  assign km_more    = (i_r < klen_r) && (kbuf_r[i_r[KIW-1:0]] != 8'd0);

  // byte store, read of p_r every cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= (st_r == S_IDLE) ? req.cmd.data : ERASED;
    rdata_r <= mem[AW'(p_r)];
    inr_r   <= (p_r < PW'(STORE_BYTES));
  end

  always_comb begin
    st_nxt     = st_r;
    p_nxt      = p_r;
    at_nxt     = at_r;
    vaddr_nxt  = vaddr_r;
    size_nxt   = size_r;
    klen_nxt   = klen_r;
    i_nxt      = i_r;
    erase_nxt  = erase_r;
    want_nxt   = want_r;
    second_nxt = second_r;
    sf_ctx_nxt = sf_ctx_r;
    ps_ctx_nxt = ps_ctx_r;
    clr_nxt    = clr_r;
    wr_en      = 1'b0;
    wr_idx     = AW'(p_r);
    pop        = 1'b0;
    kbuf_we    = 1'b0;
    emit       = 1'b0;
    key_done   = 1'b0;
    e_status   = ST_OK;
    e_kaddr    = '0;
    e_vaddr    = '0;
    e_rdata    = 8'd0;
    he_go      = 1'b0;
    he_end     = '0;
    ps_go      = 1'b0;
    ps_ret     = '0;
    bl_go      = 1'b0;
    bl_ret     = '0;

    unique case (st_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_idx  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(STORE_BYTES - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && !out_valid_r) begin
          pop = 1'b1;
          case (req.cmd.kind)
            CMD_KEY: begin
              if (klen_r < KLW'(KEY_MAX)) begin
                kbuf_we  = 1'b1;
                klen_nxt = klen_r + 1'b1;
              end
              if (req.cmd.last) begin
                erase_nxt = req.cmd.erase;
                at_nxt    = db_start_x;
                st_nxt    = S_LK_TOP;
              end
            end
            CMD_HOLE: begin
              size_nxt = req.cmd.hole_size;
              at_nxt   = db_start_x;
              st_nxt   = S_HL_TOP;
            end
            CMD_WRITE: begin
              wr_en  = (wr_addr_x < PW'(STORE_BYTES));
              wr_idx = AW'(wr_addr_x);
              emit   = 1'b1;
            end
            CMD_READ: begin
              p_nxt  = wr_addr_x;
              st_nxt = S_RD_REQ;
            end
            default: ;
          endcase
        end
      end
      S_RD_REQ: st_nxt = S_RD_USE;
      S_RD_USE: begin
        emit    = 1'b1;
        e_rdata = byte_v;
        st_nxt  = S_IDLE;
      end
      S_LK_TOP: begin
        if (at_r + PW'(4) < db_end_x) begin
          p_nxt      = at_r;
          sf_ctx_nxt = SF_LOOKUP;
          want_nxt   = 1'b0;
          st_nxt     = S_SF_REQ;
        end else begin
          emit     = 1'b1;
          e_status = ST_NOT_FOUND;
          key_done = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      S_SF_REQ: begin
        if (p_r < db_end_x) begin
          st_nxt = S_SF_USE;
        end else begin
          case (sf_ctx_r)
            SF_LOOKUP: begin
              emit     = 1'b1;
              e_status = ST_NOT_FOUND;
              key_done = 1'b1;
              st_nxt   = S_IDLE;
            end
            SF_HOLE_START: begin
              emit     = 1'b1;
              e_status = ST_NO_SPACE;
              st_nxt   = S_IDLE;
            end
            default: begin
              // run reaches the end of the area
              he_go  = 1'b1;
              he_end = db_end_x + 1'b1;
            end
          endcase
        end
      end
      S_SF_USE: begin
        if ((byte_v == ERASED) == want_r) begin
          case (sf_ctx_r)
            SF_LOOKUP: begin
              at_nxt = p_r;
              i_nxt  = '0;
              st_nxt = S_KM_TOP;
            end
            SF_HOLE_START: begin
              at_nxt     = p_r;
              want_nxt   = 1'b0;
              sf_ctx_nxt = SF_HOLE_END;
              st_nxt     = S_SF_REQ;
            end
            default: begin
              he_go  = 1'b1;
              he_end = p_r;
            end
          endcase
        end else begin
          p_nxt  = p_r + 1'b1;
          st_nxt = S_SF_REQ;
        end
      end
      S_KM_TOP: st_nxt = S_KM_USE;
      S_KM_USE: begin
        if (km_more && byte_v == kbuf_r[i_r[KIW-1:0]]) begin
          i_nxt  = i_r + 1'b1;
          p_nxt  = p_r + 1'b1;
          st_nxt = S_KM_TOP;
        end else begin
          p_nxt  = at_r + 1'b1;
          st_nxt = S_PS_REQ;
          // key matched only if the stored key ends right here
          ps_ctx_nxt = (!km_more && byte_v == 8'd0) ? PS_VALUE : PS_SKIP_KEY;
        end
      end
      S_PS_REQ: begin
        if (p_r < db_end_x) begin
          st_nxt = S_PS_USE;
        end else begin
          ps_go  = 1'b1;
          ps_ret = db_end_x;
        end
      end
      S_PS_USE: begin
        if (byte_v == ERASED) begin
          ps_go  = 1'b1;
          ps_ret = p_r;
        end else if (byte_v == 8'd0) begin
          ps_go  = 1'b1;
          ps_ret = p_r + 1'b1;
        end else begin
          p_nxt  = p_r + 1'b1;
          st_nxt = S_PS_REQ;
        end
      end
      S_BL_REQ: st_nxt = S_BL_USE;
      S_BL_USE: begin
        if (byte_v == ERASED) begin
          bl_go  = 1'b1;
          bl_ret = p_r;
        end else begin
          wr_en  = 1'b1;
          wr_idx = AW'(p_r);
          if (byte_v == 8'd0) begin
            bl_go  = 1'b1;
            bl_ret = p_r + 1'b1;
          end else begin
            p_nxt  = p_r + 1'b1;
            st_nxt = S_BL_REQ;
          end
        end
      end
      S_HL_TOP: begin
        if (at_r + size_x > db_end_x) begin
          emit     = 1'b1;
          e_status = ST_NO_SPACE;
          st_nxt   = S_IDLE;
        end else begin
          p_nxt      = at_r;
          want_nxt   = 1'b1;
          sf_ctx_nxt = SF_HOLE_START;
          st_nxt     = S_SF_REQ;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // end of an erased run found
    if (he_go) begin
      if (he_end - at_r >= size_x) begin
        emit    = 1'b1;
        e_kaddr = at_r;
        st_nxt  = S_IDLE;
      end else begin
        at_nxt = he_end;
        st_nxt = S_HL_TOP;
      end
    end

    // end of a string found
    if (ps_go) begin
      case (ps_ctx_r)
        PS_SKIP_KEY: begin
          p_nxt      = ps_ret + 1'b1;
          ps_ctx_nxt = PS_SKIP_VALUE;
          st_nxt     = S_PS_REQ;
        end
        PS_SKIP_VALUE: begin
          at_nxt = ps_ret;
          st_nxt = S_LK_TOP;
        end
        default: begin
          vaddr_nxt = ps_ret;
          if (erase_r) begin
            p_nxt      = at_r;
            second_nxt = 1'b0;
            st_nxt     = S_BL_REQ;
          end else begin
            emit     = 1'b1;
            e_kaddr  = at_r;
            e_vaddr  = ps_ret;
            key_done = 1'b1;
            st_nxt   = S_IDLE;
          end
        end
      endcase
    end

    // end of a blanked string
    if (bl_go) begin
      if (!second_r) begin
        second_nxt = 1'b1;
        p_nxt      = bl_ret;
        st_nxt     = S_BL_REQ;
      end else begin
        emit     = 1'b1;
        e_kaddr  = at_r;
        e_vaddr  = vaddr_r;
        key_done = 1'b1;
        st_nxt   = S_IDLE;
      end
    end

    if (key_done) klen_nxt = '0;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_kaddr_nxt  = out_kaddr_r;
    out_vaddr_nxt  = out_vaddr_r;
    out_rdata_nxt  = out_rdata_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = e_status;
      out_kaddr_nxt  = e_kaddr[9:0];
      out_vaddr_nxt  = e_vaddr[10:0];
      out_rdata_nxt  = e_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      klen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      klen_r      <= klen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    at_r         <= at_nxt;
    vaddr_r      <= vaddr_nxt;
    size_r       <= size_nxt;
    i_r          <= i_nxt;
    erase_r      <= erase_nxt;
    want_r       <= want_nxt;
    second_r     <= second_nxt;
    sf_ctx_r     <= sf_ctx_nxt;
    ps_ctx_r     <= ps_ctx_nxt;
    out_status_r <= out_status_nxt;
    out_kaddr_r  <= out_kaddr_nxt;
    out_vaddr_r  <= out_vaddr_nxt;
    out_rdata_r  <= out_rdata_nxt;
    if (kbuf_we) kbuf_r[klen_r[KIW-1:0]] <= req.cmd.data;
  end

  assign bstat.pop      = pop;
  assign bstat.clearing = (st_r == S_CLEAR);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.key_address   = out_kaddr_r;
  assign out_ch.value_address = out_vaddr_r;
  assign out_ch.read_data     = out_rdata_r;

`ifndef SYNTHESIS
  a_klen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    klen_r <= KLW'(KEY_MAX))
    else $error("key length beyond buffer");

  a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_CLEAR |=> st_r != S_CLEAR)
    else $error("clearing pass restarted");

  a_result_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) != S_CLEAR)
    else $error("result during clearing pass");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (st_r != S_SF_USE) && (st_r != S_KM_USE) && (st_r != S_BL_USE))
    else $error("command taken in mid scan");
`endif

endmodule

FILE: src/byte_store_key_value_engine_unit.sv
// byte_store_key_value_engine_unit: top level of the key/value byte store engine
// depends on bskv_pkg, bskv_in_if, bskv_out_if, bskv_front, bskv_back
//
// channel   dir  fields                                          handshake
// in_ch     in   func, data_byte, last, address, hole_size       valid/ready
// out_ch    out  status, key_address, value_address, read_data   valid/ready
// cfg_*     in   cfg_index selects db_start or db_end            cfg_we, no wait
//
// after reset a clearing pass writes 0xff to every byte of the store,
//   in_ch.ready stays low meanwhile
// key bytes without last and writes are done in the idle state, unused codes
//   are dropped at the front; a read passes S_RD_REQ and S_RD_USE; lookup,
//   erase and hole search walk the store a byte at a time through its single
//   read port; a lookup reads a key's bytes twice, an erase rereads the record
// the front queue holds two items, so input is taken while a result waits
module byte_store_key_value_engine_unit #(
  parameter int STORE_BYTES = 1024,
  parameter int KEY_MAX     = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bskv_in_if.sink                        in_ch,
  bskv_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bskv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [10:0]                    cfg_wdata
);
  import bskv_pkg::*;

  // record area bounds
  logic [9:0]  db_start_r;
  logic [10:0] db_end_r;

  cmd_req_t   req;    // queue head toward the sequencer
  back_stat_t bstat;  // pop and clearing status back to the front

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_start_r <= 10'd0;
      db_end_r   <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DB_START: db_start_r <= cfg_wdata[9:0];
        CFG_DB_END:   db_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: accept and classify items into the command queue
  bskv_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .bstat (bstat),
    .req   (req)
  );

  // back: byte store and scan sequencer, registered result
  bskv_back #(
    .STORE_BYTES (STORE_BYTES),
    .KEY_MAX     (KEY_MAX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .bstat    (bstat),
    .db_start (db_start_r),
    .db_end   (db_end_r),
    .out_ch   (out_ch)
  );

endmodule
